FILE: hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_SAME(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: hw/rtl/emdc_pkg.sv
`timescale 1ns / 1ps
package emdc_pkg;
  localparam int VW = 24;
  localparam int FB = 16;
  localparam int CW = 23;
  localparam int NW = 16;
  localparam int DW = VW + 1;          // difference width
  localparam int AW = CW;              // axis magnitude width inside contact
  localparam int RW = 2 * AW + 1;      // squared distance width
  localparam int PW = DW + AW;         // one dot product term
  localparam int OW = PW + 1;          // dot product magnitude
  localparam int LW = 25;              // low slice of the dot product
  localparam int QW = DW + 1;          // quotient width
  localparam int NUMW = OW + AW + 1;   // dividend width
  localparam int SW = QW + 2;          // wide signed sum for saturation

  localparam logic [CW-1:0] CONTACT_RESET = CW'(27525);
  localparam logic [NW-1:0] NUDGE_RESET = NW'(66);

  localparam logic CFG_CONTACT = 1'b0;
  localparam logic CFG_NUDGE = 1'b1;

  typedef struct packed {
    logic signed [VW-1:0] first_pos_x;
    logic signed [VW-1:0] first_pos_z;
    logic signed [VW-1:0] first_vel_x;
    logic signed [VW-1:0] first_vel_z;
    logic signed [VW-1:0] second_pos_x;
    logic signed [VW-1:0] second_pos_z;
    logic signed [VW-1:0] second_vel_x;
    logic signed [VW-1:0] second_vel_z;
  } in_t;

  typedef struct packed {
    logic hit;
    logic signed [VW-1:0] new_first_pos_x;
    logic signed [VW-1:0] new_first_pos_z;
    logic signed [VW-1:0] new_first_vel_x;
    logic signed [VW-1:0] new_first_vel_z;
    logic signed [VW-1:0] new_second_pos_x;
    logic signed [VW-1:0] new_second_pos_z;
    logic signed [VW-1:0] new_second_vel_x;
    logic signed [VW-1:0] new_second_vel_z;
  } out_t;

  // Clamp a two's complement sum to the value range.
  function automatic logic [VW-1:0] sat(input logic [SW-1:0] v);
    logic top_same;
    top_same = (v[SW-1:VW-1] == {(SW-VW+1){1'b0}}) || (v[SW-1:VW-1] == {(SW-VW+1){1'b1}});
    if (top_same) return v[VW-1:0];
    else if (v[SW-1]) return {1'b1, {(VW-1){1'b0}}};
    else return {1'b0, {(VW-1){1'b1}}};
  endfunction

  function automatic logic [SW-1:0] sext(input logic [VW-1:0] v);
    return {{(SW-VW){v[VW-1]}}, v};
  endfunction
endpackage

FILE: hw/rtl/emdc_div.sv
`timescale 1ns / 1ps
module emdc_div (
  input  logic                        clk,
  input  logic                        en,
  input  logic [emdc_pkg::NUMW-1:0]   num,
  input  logic [emdc_pkg::RW-1:0]     den,
  output logic [emdc_pkg::QW-1:0]     quo
);
  import emdc_pkg::*;

  // One quotient bit per stage; the upper dividend slice is already below den.
  logic [RW-1:0] rem_r [QW];
  logic [QW-1:0] low_r [QW];
  logic [QW-1:0] quo_r [QW];
  logic [RW-1:0] den_r [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [RW-1:0] rem_in;
    logic [QW-1:0] low_in;
    logic [QW-1:0] quo_in;
    logic [RW-1:0] den_in;
    logic [RW:0]   trial;
    if (k == 0) begin : g_first
      assign rem_in = num[NUMW-1:QW];
      assign low_in = num[QW-1:0];
      assign quo_in = '0;
      assign den_in = den;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign low_in = low_r[k-1];
      assign quo_in = quo_r[k-1];
      assign den_in = den_r[k-1];
    end
    assign trial = {rem_in, low_in[QW-1]};
    always_ff @(posedge clk) begin
      if (en) begin
        if (trial >= {1'b0, den_in}) begin
          rem_r[k] <= RW'(trial - {1'b0, den_in});
          quo_r[k] <= {quo_in[QW-2:0], 1'b1};
        end else begin
          rem_r[k] <= trial[RW-1:0];
          quo_r[k] <= {quo_in[QW-2:0], 1'b0};
        end
        low_r[k] <= {low_in[QW-2:0], 1'b0};
        den_r[k] <= den_in;
      end
    end
  end

  assign quo = quo_r[QW-1];
endmodule

FILE: hw/rtl/equal_mass_disc_collision_unit.sv
`timescale 1ns / 1ps
// Channel   Ports                        Moves
// input     in_valid/in_ready/in_data    one disc pair item (emdc_pkg::in_t)
// result    out_valid/out_ready/out_data one resolved item (emdc_pkg::out_t)
// config    cfg_we/cfg_idx/cfg_wdata     contact distance, nudge step
//
// One item enters every cycle unless the pipeline holds; each passes 33 register stages:
// six arithmetic stages, 26 stages of the restoring divider (one quotient bit each),
// one saturation and output stage. The divider depth sets the latency.
// Reset (synchronous, rst_n low) empties the pipeline and loads the default
// registers. When the output item is not taken, the whole pipeline holds.
module equal_mass_disc_collision_unit (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  emdc_pkg::in_t             in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output emdc_pkg::out_t            out_data,
  input  logic                      cfg_we,
  input  logic                      cfg_idx,
  input  logic [emdc_pkg::CW-1:0]   cfg_wdata
);
  import emdc_pkg::*;
  `include "assert_macros.svh"

  localparam int NST = 6 + QW + 1;

  typedef struct packed {
    in_t           item;
    logic          hit;
    logic          d2_nz;
    logic          both_nz;
    logic          dx_neg;
    logic          dz_neg;
    logic          qx_neg;
    logic          qz_neg;
    logic [NW-1:0] nudge;
  } carry_t;

  logic [CW-1:0] contact_r;
  logic [NW-1:0] nudge_r;
  logic [NST-1:0] vld_r;
  logic adv;

  // Config registers: to be written only while idle; the block itself does not enforce it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      contact_r <= CONTACT_RESET;
      nudge_r   <= NUDGE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_CONTACT: contact_r <= cfg_wdata;
        CFG_NUDGE:   nudge_r   <= cfg_wdata[NW-1:0];
        default: ;
      endcase
    end
  end

  // Advance everything unless the output item is stuck.
  assign adv      = !vld_r[NST-1] || out_ready;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (adv) vld_r <= {vld_r[NST-2:0], in_valid};
  end

  // Stage 1: differences.
  in_t s1_item_r;
  logic [DW-1:0] s1_dx_r, s1_dz_r, s1_dvx_r, s1_dvz_r;
  logic [CW-1:0] s1_c_r;
  logic [NW-1:0] s1_n_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_item_r <= in_data;
      s1_dx_r  <= {in_data.first_pos_x[VW-1], in_data.first_pos_x}
                - {in_data.second_pos_x[VW-1], in_data.second_pos_x};
      s1_dz_r  <= {in_data.first_pos_z[VW-1], in_data.first_pos_z}
                - {in_data.second_pos_z[VW-1], in_data.second_pos_z};
      s1_dvx_r <= {in_data.second_vel_x[VW-1], in_data.second_vel_x}
                - {in_data.first_vel_x[VW-1], in_data.first_vel_x};
      s1_dvz_r <= {in_data.second_vel_z[VW-1], in_data.second_vel_z}
                - {in_data.first_vel_z[VW-1], in_data.first_vel_z};
      s1_c_r <= contact_r;
      s1_n_r <= nudge_r;
    end
  end

  // Stage 2: magnitudes, range check, signs.
  logic [DW-1:0] adx, adz, advx, advz;
  assign adx  = s1_dx_r[DW-1]  ? (~s1_dx_r + DW'(1))  : s1_dx_r;
  assign adz  = s1_dz_r[DW-1]  ? (~s1_dz_r + DW'(1))  : s1_dz_r;
  assign advx = s1_dvx_r[DW-1] ? (~s1_dvx_r + DW'(1)) : s1_dvx_r;
  assign advz = s1_dvz_r[DW-1] ? (~s1_dvz_r + DW'(1)) : s1_dvz_r;

  in_t s2_item_r;
  logic [AW-1:0] s2_ax_r, s2_az_r;
  logic [DW-1:0] s2_avx_r, s2_avz_r;
  logic s2_inr_r, s2_n1_r, s2_n2_r, s2_dxn_r, s2_dzn_r, s2_bnz_r;
  logic [CW-1:0] s2_c_r;
  logic [NW-1:0] s2_n_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      s2_item_r <= s1_item_r;
      s2_ax_r  <= adx[AW-1:0];
      s2_az_r  <= adz[AW-1:0];
      s2_avx_r <= advx;
      s2_avz_r <= advz;
      s2_inr_r <= (adx <= {2'b0, s1_c_r}) && (adz <= {2'b0, s1_c_r});
      s2_n1_r  <= s1_dvx_r[DW-1] ^ s1_dx_r[DW-1];
      s2_n2_r  <= s1_dvz_r[DW-1] ^ s1_dz_r[DW-1];
      s2_dxn_r <= s1_dx_r[DW-1];
      s2_dzn_r <= s1_dz_r[DW-1];
      s2_bnz_r <= (s1_dx_r != '0) && (s1_dz_r != '0);
      s2_c_r   <= s1_c_r;
      s2_n_r   <= s1_n_r;
    end
  end

  // Stage 3: products.
  in_t s3_item_r;
  logic [RW-2:0] s3_sqx_r, s3_sqz_r, s3_cc_r;
  logic [PW-1:0] s3_m1_r, s3_m2_r;
  logic [AW-1:0] s3_ax_r, s3_az_r;
  logic s3_inr_r, s3_n1_r, s3_n2_r, s3_dxn_r, s3_dzn_r, s3_bnz_r;
  logic [NW-1:0] s3_n_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      s3_item_r <= s2_item_r;
      s3_sqx_r <= s2_ax_r * s2_ax_r;
      s3_sqz_r <= s2_az_r * s2_az_r;
      s3_cc_r  <= s2_c_r * s2_c_r;
      s3_m1_r  <= s2_avx_r * s2_ax_r;
      s3_m2_r  <= s2_avz_r * s2_az_r;
      s3_ax_r  <= s2_ax_r;
      s3_az_r  <= s2_az_r;
      s3_inr_r <= s2_inr_r;
      s3_n1_r  <= s2_n1_r;
      s3_n2_r  <= s2_n2_r;
      s3_dxn_r <= s2_dxn_r;
      s3_dzn_r <= s2_dzn_r;
      s3_bnz_r <= s2_bnz_r;
      s3_n_r   <= s2_n_r;
    end
  end

  // Stage 4: squared distance and dot product magnitude and sign.
  logic [OW-1:0] dot_nxt;
  logic dn_nxt;
  always_comb begin
    if (s3_n1_r == s3_n2_r) begin
      dot_nxt = {1'b0, s3_m1_r} + {1'b0, s3_m2_r};
      dn_nxt  = s3_n1_r;
    end else if (s3_m1_r >= s3_m2_r) begin
      dot_nxt = {1'b0, s3_m1_r - s3_m2_r};
      dn_nxt  = s3_n1_r;
    end else begin
      dot_nxt = {1'b0, s3_m2_r - s3_m1_r};
      dn_nxt  = s3_n2_r;
    end
  end

  in_t s4_item_r;
  logic [RW-1:0] s4_d2_r;
  logic [RW-2:0] s4_cc_r;
  logic [OW-1:0] s4_dot_r;
  logic [AW-1:0] s4_ax_r, s4_az_r;
  logic s4_inr_r, s4_dn_r, s4_dxn_r, s4_dzn_r, s4_bnz_r;
  logic [NW-1:0] s4_n_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      s4_item_r <= s3_item_r;
      s4_d2_r  <= {1'b0, s3_sqx_r} + {1'b0, s3_sqz_r};
      s4_cc_r  <= s3_cc_r;
      s4_dot_r <= dot_nxt;
      s4_dn_r  <= dn_nxt;
      s4_ax_r  <= s3_ax_r;
      s4_az_r  <= s3_az_r;
      s4_inr_r <= s3_inr_r;
      s4_dxn_r <= s3_dxn_r;
      s4_dzn_r <= s3_dzn_r;
      s4_bnz_r <= s3_bnz_r;
      s4_n_r   <= s3_n_r;
    end
  end

  // Stage 5: contact decision, split dividend products.
  in_t s5_item_r;
  logic [RW-1:0] s5_d2_r;
  logic [LW+AW-1:0] s5_pxl_r, s5_pzl_r;
  logic [OW-LW+AW-1:0] s5_pxh_r, s5_pzh_r;
  logic s5_hit_r, s5_dn_r, s5_dxn_r, s5_dzn_r, s5_bnz_r;
  logic [NW-1:0] s5_n_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      s5_item_r <= s4_item_r;
      s5_d2_r  <= s4_d2_r;
      s5_hit_r <= s4_inr_r && (s4_d2_r <= {1'b0, s4_cc_r});
      s5_pxl_r <= s4_dot_r[LW-1:0] * s4_ax_r;
      s5_pzl_r <= s4_dot_r[LW-1:0] * s4_az_r;
      s5_pxh_r <= s4_dot_r[OW-1:LW] * s4_ax_r;
      s5_pzh_r <= s4_dot_r[OW-1:LW] * s4_az_r;
      s5_dn_r  <= s4_dn_r;
      s5_dxn_r <= s4_dxn_r;
      s5_dzn_r <= s4_dzn_r;
      s5_bnz_r <= s4_bnz_r;
      s5_n_r   <= s4_n_r;
    end
  end

  // Stage 6: dividends with half the divisor added for rounding.
  logic [NUMW-1:0] s6_numx_r, s6_numz_r;
  logic [RW-1:0] s6_d2_r;
  carry_t s6_carry_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      s6_numx_r <= {s5_pxh_r, {LW{1'b0}}} + NUMW'(s5_pxl_r) + NUMW'(s5_d2_r >> 1);
      s6_numz_r <= {s5_pzh_r, {LW{1'b0}}} + NUMW'(s5_pzl_r) + NUMW'(s5_d2_r >> 1);
      s6_d2_r   <= s5_d2_r;
      s6_carry_r.item    <= s5_item_r;
      s6_carry_r.hit     <= s5_hit_r;
      s6_carry_r.d2_nz   <= (s5_d2_r != '0);
      s6_carry_r.both_nz <= s5_bnz_r;
      s6_carry_r.dx_neg  <= s5_dxn_r;
      s6_carry_r.dz_neg  <= s5_dzn_r;
      s6_carry_r.qx_neg  <= s5_dn_r ^ s5_dxn_r;
      s6_carry_r.qz_neg  <= s5_dn_r ^ s5_dzn_r;
      s6_carry_r.nudge   <= s5_n_r;
    end
  end

  // Divider stages, side data travels alongside.
  logic [QW-1:0] qx, qz;
  emdc_div u_div_x (.clk(clk), .en(adv), .num(s6_numx_r), .den(s6_d2_r), .quo(qx));
  emdc_div u_div_z (.clk(clk), .en(adv), .num(s6_numz_r), .den(s6_d2_r), .quo(qz));

  carry_t carry_r [QW];
  always_ff @(posedge clk) begin
    if (adv) begin
      carry_r[0] <= s6_carry_r;
      for (int k = 1; k < QW; k++) carry_r[k] <= carry_r[k-1];
    end
  end

  // Output stage: apply exchange and nudge, saturate.
  carry_t cf;
  logic [SW-1:0] ex, ez, sn;
  out_t out_nxt, out_r;
  assign cf = carry_r[QW-1];
  assign ex = cf.qx_neg ? (~{2'b0, qx} + SW'(1)) : {2'b0, qx};
  assign ez = cf.qz_neg ? (~{2'b0, qz} + SW'(1)) : {2'b0, qz};
  assign sn = SW'(cf.nudge);

  always_comb begin
    out_nxt.hit              = cf.hit;
    out_nxt.new_first_pos_x  = cf.item.first_pos_x;
    out_nxt.new_first_pos_z  = cf.item.first_pos_z;
    out_nxt.new_first_vel_x  = cf.item.first_vel_x;
    out_nxt.new_first_vel_z  = cf.item.first_vel_z;
    out_nxt.new_second_pos_x = cf.item.second_pos_x;
    out_nxt.new_second_pos_z = cf.item.second_pos_z;
    out_nxt.new_second_vel_x = cf.item.second_vel_x;
    out_nxt.new_second_vel_z = cf.item.second_vel_z;
    if (cf.hit && cf.d2_nz) begin
      out_nxt.new_first_vel_x  = sat(sext(cf.item.first_vel_x) + ex);
      out_nxt.new_first_vel_z  = sat(sext(cf.item.first_vel_z) + ez);
      out_nxt.new_second_vel_x = sat(sext(cf.item.second_vel_x) - ex);
      out_nxt.new_second_vel_z = sat(sext(cf.item.second_vel_z) - ez);
    end
    if (cf.hit && cf.both_nz) begin
      // Push the first disc away from the second along each axis.
      out_nxt.new_first_pos_x  = cf.dx_neg ? sat(sext(cf.item.first_pos_x) - sn)
                                           : sat(sext(cf.item.first_pos_x) + sn);
      out_nxt.new_second_pos_x = cf.dx_neg ? sat(sext(cf.item.second_pos_x) + sn)
                                           : sat(sext(cf.item.second_pos_x) - sn);
      out_nxt.new_first_pos_z  = cf.dz_neg ? sat(sext(cf.item.first_pos_z) - sn)
                                           : sat(sext(cf.item.first_pos_z) + sn);
      out_nxt.new_second_pos_z = cf.dz_neg ? sat(sext(cf.item.second_pos_z) + sn)
                                           : sat(sext(cf.item.second_pos_z) - sn);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) out_r <= out_nxt;
  end

  assign out_valid = vld_r[NST-1];
  assign out_data  = out_r;

  `ASSERT_NEXT(a_accept_enters, clk, rst_n, in_valid && in_ready, vld_r[0])
  `ASSERT_NEXT(a_stall_holds, clk, rst_n, !adv, vld_r == $past(vld_r))
  `ASSERT_SAME(a_miss_keeps_vel, clk, rst_n, adv && vld_r[NST-2] && !cf.hit,
               out_nxt.new_first_vel_x == cf.item.first_vel_x)
endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import emdc_pkg::*;

  // Q8.16 signed range of every position and velocity field.
  localparam logic signed [VW-1:0] VAL_MAX = {1'b0, {(VW-1){1'b1}}};
  localparam logic signed [VW-1:0] VAL_MIN = {1'b1, {(VW-1){1'b0}}};
  localparam int DRAIN_CYCLES = 60;    // pipeline is 33 deep; wait a little longer

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_t in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;
  logic cfg_we;
  logic cfg_idx;
  logic [CW-1:0] cfg_wdata;

  equal_mass_disc_collision_unit u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
  );

  // Copy of the two registers as the block should hold them.
  logic [CW-1:0] contact_dist;
  logic [NW-1:0] nudge;

  out_t resolved_q[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  always begin
    clk = 1'b1; #10;
    clk = 1'b0; #10;
  end

  // Clamp a wide signed value to the field range.
  function automatic logic signed [VW-1:0] clamp(input longint v);
    if (v > longint'(VAL_MAX)) return VAL_MAX;
    if (v < longint'(VAL_MIN)) return VAL_MIN;
    return VW'(v);
  endfunction

  // Exchange term dot*axis/d2, rounded half away from zero, in 128-bit arithmetic.
  function automatic longint exchange_term(input logic signed [127:0] dot, input longint axis,
                                           input longint d2);
    logic signed [127:0] num;
    logic [127:0] mag_num;
    logic [127:0] q;
    num = dot * 128'(signed'(axis));
    mag_num = num < 0 ? -num : num;
    q = (mag_num + 128'(d2 / 2)) / 128'(d2);
    return num < 0 ? -longint'(q) : longint'(q);
  endfunction

  // Predict the resolved pair for one accepted disc pair.
  function automatic out_t resolve_pair(input in_t p);
    out_t r;
    longint dx, dz, dvx, dvz, d2, ex, ez, s, sx, sz, c, adx, adz;
    logic signed [127:0] dot;
    r.hit = 1'b0;
    r.new_first_pos_x = p.first_pos_x;
    r.new_first_pos_z = p.first_pos_z;
    r.new_first_vel_x = p.first_vel_x;
    r.new_first_vel_z = p.first_vel_z;
    r.new_second_pos_x = p.second_pos_x;
    r.new_second_pos_z = p.second_pos_z;
    r.new_second_vel_x = p.second_vel_x;
    r.new_second_vel_z = p.second_vel_z;
    dx = longint'(p.first_pos_x) - longint'(p.second_pos_x);
    dz = longint'(p.first_pos_z) - longint'(p.second_pos_z);
    adx = dx < 0 ? -dx : dx;
    adz = dz < 0 ? -dz : dz;
    c = longint'(contact_dist);
    if (adx <= c && adz <= c) begin
      d2 = adx * adx + adz * adz;
      if (d2 <= c * c) begin
        r.hit = 1'b1;
        if (d2 != 0) begin
          dvx = longint'(p.second_vel_x) - longint'(p.first_vel_x);
          dvz = longint'(p.second_vel_z) - longint'(p.first_vel_z);
          dot = 128'(signed'(dvx)) * 128'(signed'(dx)) + 128'(signed'(dvz)) * 128'(signed'(dz));
          ex = exchange_term(dot, dx, d2);
          ez = exchange_term(dot, dz, d2);
          r.new_first_vel_x = clamp(longint'(p.first_vel_x) + ex);
          r.new_first_vel_z = clamp(longint'(p.first_vel_z) + ez);
          r.new_second_vel_x = clamp(longint'(p.second_vel_x) - ex);
          r.new_second_vel_z = clamp(longint'(p.second_vel_z) - ez);
        end
        // Push apart only when both axes differ.
        if (dx != 0 && dz != 0) begin
          s = longint'(nudge);
          sx = dx > 0 ? s : -s;
          sz = dz > 0 ? s : -s;
          r.new_first_pos_x = clamp(longint'(p.first_pos_x) + sx);
          r.new_first_pos_z = clamp(longint'(p.first_pos_z) + sz);
          r.new_second_pos_x = clamp(longint'(p.second_pos_x) - sx);
          r.new_second_pos_z = clamp(longint'(p.second_pos_z) - sz);
        end
      end
    end
    return r;
  endfunction

  // Hand one item to the block, holding it until accepted; record what it should give.
  // Valid stays high on return; drop it only when idling.
  task automatic send_pair(input in_t p, input bit has_exp, input out_t exp_r);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
      while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= p;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    resolved_q.push_back(has_exp ? exp_r : resolve_pair(p));
    @(negedge clk);
  endtask

  // Wait for the pipeline to empty, then write one register.
  task automatic write_reg(input logic idx, input logic [CW-1:0] val);
    in_valid <= 1'b0;
    while (resolved_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_CONTACT) contact_dist = val;
    else nudge = NW'(val);
  endtask

  // Compare each result with the oldest expectation.
  always @(posedge clk) begin
    out_t e;
    if (rst_n && out_valid && out_ready) begin
      if (resolved_q.size() == 0) begin
        $display("%0t: unexpected item, actual %h", $time, out_data);
        errors++;
      end else begin
        e = resolved_q.pop_front();
        if (out_data !== e) begin
          $display("%0t: mismatch expected %h actual %h", $time, e, out_data);
          errors++;
        end
      end
    end
  end

  // Receiver stall, redrawn on each falling edge.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  function automatic in_t pair(input longint ax, az, avx, avz, bx, bz, bvx, bvz);
    in_t p;
    p.first_pos_x = VW'(ax); p.first_pos_z = VW'(az);
    p.first_vel_x = VW'(avx); p.first_vel_z = VW'(avz);
    p.second_pos_x = VW'(bx); p.second_pos_z = VW'(bz);
    p.second_vel_x = VW'(bvx); p.second_vel_z = VW'(bvz);
    return p;
  endfunction

  function automatic logic signed [VW-1:0] rand_val();
    return VW'($urandom);
  endfunction

  // Mostly pairs near contact, with random velocities; some fully random noise.
  function automatic in_t random_pair();
    in_t p;
    int span;
    p.first_vel_x = rand_val(); p.first_vel_z = rand_val();
    p.second_vel_x = rand_val(); p.second_vel_z = rand_val();
    p.first_pos_x = rand_val(); p.first_pos_z = rand_val();
    if ($urandom_range(9) < 2) begin
      p.second_pos_x = rand_val(); p.second_pos_z = rand_val();
    end else begin
      span = int'(contact_dist) + 2;
      p.second_pos_x = p.first_pos_x + VW'($urandom_range(2 * span) - span);
      p.second_pos_z = p.first_pos_z + VW'($urandom_range(2 * span) - span);
      if ($urandom_range(7) == 0) p.second_pos_z = p.first_pos_z;
      if ($urandom_range(15) == 0) begin
        p.second_pos_x = p.first_pos_x;
        p.second_pos_z = p.first_pos_z;
      end
      if ($urandom_range(3) == 0) begin
        // small velocities keep most arithmetic unsaturated
        p.first_vel_x = VW'(signed'(p.first_vel_x) >>> 8);
        p.second_vel_z = VW'(signed'(p.second_vel_z) >>> 8);
      end
    end
    return p;
  endfunction

  // Directed rows: stimulus and, where obvious, its expected result.
  typedef struct {
    in_t stim;
    bit has_exp;
    out_t exp_r;
  } dir_row_t;

  initial begin
    dir_row_t rows[$];
    dir_row_t row;
    out_t x;
    int phase;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = CFG_CONTACT;
    cfg_wdata = '0;
    contact_dist = CONTACT_RESET;
    nudge = NUDGE_RESET;
    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    // Far apart after reset: no hit, everything passes through.
    row.stim = pair(0, 0, 5, 6, 65536, 65536, 7, 8);
    row.has_exp = 1;
    row.exp_r = {1'b0, 24'sd0, 24'sd0, 24'sd5, 24'sd6, 24'sd65536, 24'sd65536, 24'sd7, 24'sd8};
    rows.push_back(row);
    // Coincident centres: hit, velocities kept, no nudge.
    row.stim = pair(100, 200, 1, 2, 100, 200, 3, 4);
    row.exp_r = {1'b1, 24'sd100, 24'sd200, 24'sd1, 24'sd2, 24'sd100, 24'sd200, 24'sd3, 24'sd4};
    rows.push_back(row);
    // Head-on along x, equal on z: velocities swap, no nudge.
    row.stim = pair(10000, 0, 65536, 0, 0, 0, -65536, 0);
    row.exp_r = {1'b1, 24'sd10000, 24'sd0, -24'sd65536, 24'sd0,
                 24'sd0, 24'sd0, 24'sd65536, 24'sd0};
    rows.push_back(row);
    row.has_exp = 0;
    rows.push_back('{pair(0, 10000, 0, 3000, 0, 0, 0, -3000), 0, x});
    rows.push_back('{pair(10000, 10000, 1000, -2000, 0, 0, -500, 700), 0, x});
    rows.push_back('{pair(-10000, 12000, 1000, 2000, 0, 0, -500, 700), 0, x});
    rows.push_back('{pair(27525, 0, 1, 1, 0, 0, 1, 1), 0, x});
    rows.push_back('{pair(27526, 0, 1, 1, 0, 0, 1, 1), 0, x});
    rows.push_back('{pair(19463, 19463, 0, 0, 0, 0, 65536, 65536), 0, x});
    rows.push_back('{pair(19464, 19464, 0, 0, 0, 0, 65536, 65536), 0, x});
    // Field extremes, saturation of positions and velocities.
    rows.push_back('{pair(VAL_MAX, VAL_MAX, VAL_MAX, VAL_MAX, VAL_MAX - 100, VAL_MAX - 100,
                          VAL_MIN, VAL_MIN), 0, x});
    rows.push_back('{pair(VAL_MIN, VAL_MIN, VAL_MIN, VAL_MAX, VAL_MIN + 100, VAL_MIN + 50,
                          VAL_MAX, VAL_MIN), 0, x});
    rows.push_back('{pair(VAL_MAX, VAL_MIN, 0, 0, VAL_MIN, VAL_MAX, 0, 0), 0, x});
    rows.push_back('{pair(-1, -1, -1, -1, -1, -1, -1, -1), 0, x});
    rows.push_back('{pair(1, -1, VAL_MAX, VAL_MIN, 0, 0, VAL_MIN, VAL_MAX), 0, x});
    rows.push_back('{pair(3, 1, 7, -7, 0, 0, 0, 0), 0, x});
    foreach (rows[i]) send_pair(rows[i].stim, rows[i].has_exp, rows[i].exp_r);

    // Nudge extremes, zero and widest contact distance.
    write_reg(CFG_NUDGE, CW'(16'hFFFF));
    send_pair(pair(VAL_MAX, VAL_MIN, 5, 5, VAL_MAX - 9, VAL_MIN + 9, -5, -5), 0, x);
    send_pair(pair(20, -20, 1, 2, 0, 0, 3, 4), 0, x);
    write_reg(CFG_CONTACT, '0);
    send_pair(pair(0, 0, 1, 2, 0, 0, 3, 4), 0, x);
    send_pair(pair(1, 0, 1, 2, 0, 0, 3, 4), 0, x);
    write_reg(CFG_NUDGE, '0);
    write_reg(CFG_CONTACT, {CW{1'b1}});
    send_pair(pair(VAL_MAX, VAL_MAX, VAL_MAX, VAL_MIN, 0, 0, VAL_MIN, VAL_MAX), 0, x);
    send_pair(pair(-4000000, 4000000, 12345, -54321, 3000000, -2000000, -9999, 8888), 0, x);

    // Random part in three idling phases, each with its own register setting.
    for (phase = 0; phase < 3; phase++) begin
      send_idle_pct = phase == 0 ? 20 : (phase == 1 ? 77 : 0);
      recv_idle_pct = phase == 0 ? 77 : (phase == 1 ? 20 : 0);
      write_reg(CFG_CONTACT, phase == 2 ? CW'($urandom) : CW'($urandom_range(200000)));
      write_reg(CFG_NUDGE, CW'(16'($urandom)));
      repeat (210) send_pair(random_pair(), 0, x);
    end
    write_reg(CFG_CONTACT, CONTACT_RESET);
    write_reg(CFG_NUDGE, CW'(NUDGE_RESET));
    repeat (20) send_pair(random_pair(), 0, x);

    in_valid <= 1'b0;
    while (resolved_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (errors == 0 && resolved_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Simulation FAILED");
    $finish;
  end
endmodule
